// ----- rtl/htlp_pkg.sv -----
// shared types, constants and the home-slot hash for the linear-probe hash table
package htlp_pkg;

   localparam int TABLE_SLOTS = 256;
   localparam int KEY_BYTES   = 4;
   localparam int DATA_BYTES  = 4;

   localparam int HASH_START  = 5381;
   localparam int HASH_SHIFT  = 5;

   // port widths are fixed by the interface
   localparam int OP_W        = 2;
   localparam int KEY_PORT_W  = 32;
   localparam int VAL_PORT_W  = 32;
   localparam int STAT_W      = 2;
   localparam int SLOT_PORT_W = 8;
   localparam int CNT_PORT_W  = 9;

   // stored widths, bytes above the port width count as zero
   localparam int KEY_SW  = (8 * KEY_BYTES < KEY_PORT_W) ? 8 * KEY_BYTES : KEY_PORT_W;
   localparam int DATA_SW = (8 * DATA_BYTES < VAL_PORT_W) ? 8 * DATA_BYTES : VAL_PORT_W;

   // table size is a power of two, so the hash can be kept at slot width
   localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
   localparam int CNT_BITS  = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_SEARCH,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [KEY_SW-1:0]  key;
      logic [DATA_SW-1:0] data;
   } entry_type;

   typedef struct packed {
      logic                 we;
      logic [SLOT_BITS-1:0] addr;
      entry_type            wdata;
   } ram_req_type;

   typedef struct packed {
      status_type             status;
      logic [VAL_PORT_W-1:0]  found_value;
      logic [SLOT_PORT_W-1:0] slot_index;
      logic [CNT_PORT_W-1:0]  occupied_count;
   } rsp_beat_type;

   // djb2 over the key bytes, low byte first, kept modulo the slot count
   function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_SW-1:0] key);
      logic [63:0]          kx;
      logic [SLOT_BITS-1:0] h;
      kx = 64'(key);
      h  = SLOT_BITS'(HASH_START);
      for (int i = 0; i < KEY_BYTES; i++) begin
         h = SLOT_BITS'(h << HASH_SHIFT) + h + SLOT_BITS'(kx[8*i +: 8]);
      end
      return h;
   endfunction

endpackage

// ----- rtl/htlp_ram.sv -----
// single-port synchronous ram, one write or one read per cycle, registered read data
module htlp_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/htlp_probe.sv -----
// probe sequencer: hashing, occupancy bits, slot scan and result formation
module htlp_probe
   import htlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [OP_W-1:0]       req_op,
   input  logic [KEY_PORT_W-1:0] req_key,
   input  logic [VAL_PORT_W-1:0] req_value,
   output logic                  req_stall,
   output ram_req_type           ram_req,
   input  entry_type             ram_rdata,
   output logic                  res_valid,
   output rsp_beat_type          res,
   input  logic                  res_take
);

   fsm_state_type        state_ff, state_in;
   logic                 del_ff, del_in;
   logic [KEY_SW-1:0]    key_ff, key_in;
   logic [DATA_SW-1:0]   val_ff, val_in;
   logic [SLOT_BITS-1:0] addr_ff, addr_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 p_vld_ff, p_vld_in;
   logic                 p_used_ff, p_used_in;
   logic                 p_last_ff, p_last_in;
   logic [SLOT_BITS-1:0] p_addr_ff, p_addr_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;
   rsp_beat_type         res_ff, res_in;

   logic                 accept;
   logic                 is_insert;
   logic                 table_full;
   logic                 hit;
   logic                 miss;
   logic [KEY_SW-1:0]    key_trim;
   logic [SLOT_BITS-1:0] addr_next;

   assign accept     = req_valid && !req_stall;
   assign is_insert  = (req_op == OP_INSERT);
   assign table_full = (total_ff == CNT_BITS'(TABLE_SLOTS));
   assign key_trim   = KEY_SW'(req_key);
   assign addr_next  = (addr_ff == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : addr_ff + 1'b1;

   // compare stage sees the entry whose read was issued in the cycle before
   assign hit  = p_vld_ff && p_used_ff && (ram_rdata.key == key_ff);
   assign miss = p_vld_ff && p_last_ff && !hit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (is_insert) begin
                  state_in = table_full ? S_DONE : S_INSERT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_INSERT: begin
            if (!used_ff[addr_ff]) state_in = S_DONE;
         end
         S_SEARCH: begin
            if (hit || miss) state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      del_in    = del_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      p_vld_in  = 1'b0;
      p_used_in = used_ff[addr_ff];
      p_last_in = (cnt_ff == CNT_BITS'(TABLE_SLOTS - 1));
      p_addr_in = addr_ff;
      used_in   = used_ff;
      total_in  = total_ff;
      res_in    = res_ff;
      ram_req.we    = 1'b0;
      ram_req.addr  = addr_ff;
      ram_req.wdata = '{key: key_ff, data: val_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               del_in  = (req_op == OP_DELETE);
               key_in  = key_trim;
               val_in  = DATA_SW'(req_value);
               addr_in = home_slot(key_trim);
               cnt_in  = '0;
               res_in.status         = STAT_FULL;
               res_in.found_value    = '0;
               res_in.slot_index     = '0;
               res_in.occupied_count = CNT_PORT_W'(total_ff);
            end
         end
         S_INSERT: begin
            if (!used_ff[addr_ff]) begin
               ram_req.we       = 1'b1;
               used_in[addr_ff] = 1'b1;
               total_in         = total_ff + 1'b1;
               res_in.status         = STAT_OK;
               res_in.slot_index     = SLOT_PORT_W'(addr_ff);
               res_in.occupied_count = CNT_PORT_W'(total_ff + 1'b1);
            end else begin
               addr_in = addr_next;
            end
         end
         S_SEARCH: begin
            // issue one slot read per cycle until every slot has been visited
            if (cnt_ff != CNT_BITS'(TABLE_SLOTS)) begin
               p_vld_in = 1'b1;
               addr_in  = addr_next;
               cnt_in   = cnt_ff + 1'b1;
            end
            if (hit) begin
               res_in.status     = STAT_OK;
               res_in.slot_index = SLOT_PORT_W'(p_addr_ff);
               if (del_ff) begin
                  used_in[p_addr_ff]    = 1'b0;
                  total_in              = total_ff - 1'b1;
                  res_in.occupied_count = CNT_PORT_W'(total_ff - 1'b1);
               end else begin
                  res_in.found_value = VAL_PORT_W'(ram_rdata.data);
               end
            end else if (miss) begin
               res_in.status = STAT_MISS;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         p_vld_ff <= 1'b0;
         used_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         p_vld_ff <= p_vld_in;
         used_ff  <= used_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      del_ff    <= del_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      p_used_ff <= p_used_in;
      p_last_ff <= p_last_in;
      p_addr_ff <= p_addr_in;
      res_ff    <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

// ----- rtl/hash_table_linear_probe.sv -----
// top level of the linear-probe hash table: probe sequencer, slot ram, response register
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   op, key, value
//   rsp      out        rsp_valid/rsp_stall   status, found_value, slot_index, occupied_count
//
// one item at a time; a lookup or delete reads one slot of the key/data ram per cycle
// and scans until a hit ends it early or every slot has been read;
// an insert walks the occupancy bits one slot per cycle until it finds a free slot;
// an insert into a full table is answered without a walk
// synchronous reset empties the table at once, the ram contents need no clearing
// the response register frees the sequencer, so one more item is taken while rsp is stalled
module hash_table_linear_probe
   import htlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [KEY_PORT_W-1:0]  req_key,
   input  logic [VAL_PORT_W-1:0]  req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [VAL_PORT_W-1:0]  rsp_found_value,
   output logic [SLOT_PORT_W-1:0] rsp_slot_index,
   output logic [CNT_PORT_W-1:0]  rsp_occupied_count
);

   ram_req_type  ram_req;
   entry_type    ram_rdata;
   logic         res_valid;
   rsp_beat_type res;
   logic         out_free;
   logic         load;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   htlp_probe u_probe (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_key   (req_key),
      .req_value (req_value),
      .req_stall (req_stall),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (out_free)
   );

   htlp_ram #(
      .ADDR_W (SLOT_BITS),
      .DATA_W ($bits(entry_type))
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   // response beat register
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = res_valid && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign rsp_beat_in  = load ? res : rsp_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_beat_ff.status;
   assign rsp_found_value    = rsp_beat_ff.found_value;
   assign rsp_slot_index     = rsp_beat_ff.slot_index;
   assign rsp_occupied_count = rsp_beat_ff.occupied_count;

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the linear-probe hash table: directed table, then random phases
`timescale 1ns / 100ps

module tb;
   import htlp_pkg::*;

   localparam logic [OP_W-1:0] OP_ALIAS_LOOKUP = 2'd3;
   localparam int LONG_HOLD      = 2500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 60;
   localparam int POOL_SIZE      = 32;

   typedef struct {
      logic [OP_W-1:0]       op;
      logic [KEY_PORT_W-1:0] key;
      logic [VAL_PORT_W-1:0] value;
      bit                    typed;
      rsp_beat_type          rsp;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op;
   logic [KEY_PORT_W-1:0]  req_key;
   logic [VAL_PORT_W-1:0]  req_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STAT_W-1:0]      rsp_status;
   logic [VAL_PORT_W-1:0]  rsp_found_value;
   logic [SLOT_PORT_W-1:0] rsp_slot_index;
   logic [CNT_PORT_W-1:0]  rsp_occupied_count;

   // shadow copy of the table
   bit                    occ_bit  [TABLE_SLOTS];
   logic [KEY_PORT_W-1:0] key_mem  [TABLE_SLOTS];
   logic [VAL_PORT_W-1:0] data_mem [TABLE_SLOTS];
   int                    occ_total;

   rsp_beat_type          pending_rsp [$];
   dir_row_type           directed_rows [$];
   logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];

   int  errors;
   int  items_sent;
   int  rsp_checked;
   int  full_seen;
   int  miss_seen;
   int  peak_occ;
   int  holds_done;
   bit  quiet;
   bit  hold_req;

   hash_table_linear_probe dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_key            (req_key),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_value    (rsp_found_value),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_occupied_count (rsp_occupied_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int djb2_slot(input logic [KEY_PORT_W-1:0] key);
      logic [63:0] h;
      h = 64'(HASH_START);
      for (int i = 0; i < KEY_BYTES; i++) begin
         h = (h << HASH_SHIFT) + h + 64'(key[8*i +: 8]);
      end
      return int'(h % 64'(TABLE_SLOTS));
   endfunction

   // apply one request to the shadow table and work out its response
   task automatic probe_table(input logic [OP_W-1:0] op, input logic [KEY_PORT_W-1:0] key,
                              input logic [VAL_PORT_W-1:0] value, output rsp_beat_type r);
      int  home;
      int  idx;
      bit  hit;
      home = djb2_slot(key);
      hit  = 1'b0;
      r    = '0;
      r.status = STAT_MISS;
      if (op == OP_INSERT) begin
         r.status = STAT_FULL;
         for (int n = 0; n < TABLE_SLOTS && !hit; n++) begin
            idx = (home + n) % TABLE_SLOTS;
            if (!occ_bit[idx]) begin
               occ_bit[idx]  = 1'b1;
               key_mem[idx]  = key;
               data_mem[idx] = value;
               occ_total++;
               r.status     = STAT_OK;
               r.slot_index = idx[SLOT_PORT_W-1:0];
               hit = 1'b1;
            end
         end
         if (!hit) full_seen++;
      end else begin
         // delete, lookup and the spare code all search the full probe order
         for (int n = 0; n < TABLE_SLOTS && !hit; n++) begin
            idx = (home + n) % TABLE_SLOTS;
            if (occ_bit[idx] && key_mem[idx] == key) begin
               hit = 1'b1;
               r.status     = STAT_OK;
               r.slot_index = idx[SLOT_PORT_W-1:0];
               if (op == OP_DELETE) begin
                  occ_bit[idx] = 1'b0;
                  if (occ_total > 0) occ_total--;
               end else begin
                  r.found_value = data_mem[idx];
               end
            end
         end
         if (!hit) miss_seen++;
      end
      if (occ_total > peak_occ) peak_occ = occ_total;
      r.occupied_count = occ_total[CNT_PORT_W-1:0];
   endtask

   function automatic dir_row_type mk_row(input logic [OP_W-1:0] op,
                                          input logic [KEY_PORT_W-1:0] key,
                                          input logic [VAL_PORT_W-1:0] value, input bit typed,
                                          input status_type st, input int count);
      dir_row_type r;
      r.op    = op;
      r.key   = key;
      r.value = value;
      r.typed = typed;
      r.rsp   = '0;
      r.rsp.status         = st;
      r.rsp.occupied_count = count[CNT_PORT_W-1:0];
      return r;
   endfunction

   // key of a random occupied slot, call only when the table is not empty
   function automatic logic [KEY_PORT_W-1:0] stored_key();
      int s;
      s = $urandom_range(0, TABLE_SLOTS - 1);
      while (!occ_bit[s]) s = (s + 1) % TABLE_SLOTS;
      return key_mem[s];
   endfunction

   function automatic logic [KEY_PORT_W-1:0] any_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom_range(0, 1) ? '1 : '0;
      if (sel <= 4) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [KEY_PORT_W-1:0] pick_key(input int pct_present);
      if (occ_total > 0 && $urandom_range(0, 99) < pct_present) return stored_key();
      return any_key();
   endfunction

   function automatic logic [VAL_PORT_W-1:0] rand_value();
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? '1 : '0;
      return $urandom;
   endfunction

   task automatic flag_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("tb: mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_PORT_W-1:0] key,
                            input logic [VAL_PORT_W-1:0] value, input bit typed,
                            input rsp_beat_type typed_rsp);
      rsp_beat_type pred;
      int           gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      probe_table(op, key, value, pred);
      pending_rsp.push_back(typed ? typed_rsp : pred);
      items_sent++;
   endtask

   task automatic random_items(input int count, input int ins_pct, input int del_pct);
      int                    sel;
      logic [OP_W-1:0]       op;
      logic [KEY_PORT_W-1:0] key;
      rsp_beat_type          blank;
      blank = '0;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < ins_pct) begin
            op  = OP_INSERT;
            // some inserts repeat a stored key on purpose
            key = ($urandom_range(0, 4) == 0 && occ_total > 0) ? stored_key() : any_key();
         end else if (sel < ins_pct + del_pct) begin
            op  = OP_DELETE;
            key = pick_key(75);
         end else begin
            op  = ($urandom_range(0, 7) == 0) ? OP_ALIAS_LOOKUP : OP_LOOKUP;
            key = pick_key(60);
         end
         send_item(op, key, rand_value(), 1'b0, blank);
      end
   endtask

   task automatic check_response();
      rsp_beat_type want;
      rsp_checked++;
      if (pending_rsp.size() == 0) begin
         flag_mismatch("response with nothing outstanding");
      end else begin
         want = pending_rsp.pop_front();
         if (rsp_status !== want.status)
            flag_mismatch($sformatf("rsp %0d status %0d want %0d", rsp_checked,
                                    rsp_status, want.status));
         if (rsp_found_value !== want.found_value)
            flag_mismatch($sformatf("rsp %0d found_value %h want %h", rsp_checked,
                                    rsp_found_value, want.found_value));
         if (rsp_slot_index !== want.slot_index)
            flag_mismatch($sformatf("rsp %0d slot_index %0d want %0d", rsp_checked,
                                    rsp_slot_index, want.slot_index));
         if (rsp_occupied_count !== want.occupied_count)
            flag_mismatch($sformatf("rsp %0d occupied_count %0d want %0d", rsp_checked,
                                    rsp_occupied_count, want.occupied_count));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_response();
   end

   // response side back-pressure: random bursts plus an occasional long hold
   initial begin
      int burst_left;
      int hold_left;
      burst_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall  <= 1'b1;
            burst_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycles with no beat on either channel
   initial begin
      int dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) dead_cycles = 0;
         else dead_cycles++;
      end
      $display("tb: watchdog expired, %0d responses outstanding", pending_rsp.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      int guard;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = '0;
      req_key   = '0;
      req_value = '0;
      errors = 0; items_sent = 0; rsp_checked = 0;
      full_seen = 0; miss_seen = 0; peak_occ = 0; holds_done = 0;
      quiet = 1'b0; hold_req = 1'b0;
      occ_total = 0;
      foreach (occ_bit[s]) occ_bit[s] = 1'b0;

      // pairs of keys that share a home slot: byte 2 down one, byte 3 up 33
      for (int p = 0; p < POOL_SIZE; p += 2) begin
         key_pool[p]     = $urandom;
         key_pool[p + 1] = {key_pool[p][31:24] + 8'd33, key_pool[p][23:16] - 8'd1,
                            key_pool[p][15:0]};
      end

      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h0, 32'h0, 1, STAT_MISS, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'hffff_ffff, 32'h0, 1, STAT_MISS, 0));
      directed_rows.push_back(mk_row(OP_INSERT, 32'h0, 32'hffff_ffff, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_INSERT, 32'hffff_ffff, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h0, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'hffff_ffff, 32'h0, 0, STAT_OK, 0));
      // colliding pair, the second one probes past the first
      directed_rows.push_back(mk_row(OP_INSERT, 32'h0001_0000, 32'h1234_5678, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_INSERT, 32'h2100_0000, 32'h9abc_def0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h2100_0000, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h0001_0000, 32'h0, 0, STAT_OK, 0));
      // search must step over the freed slot
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h2100_0000, 32'h0, 0, STAT_OK, 0));
      // duplicate key lands in the freed slot ahead of the older copy
      directed_rows.push_back(mk_row(OP_INSERT, 32'h2100_0000, 32'h0000_0001, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h2100_0000, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_ALIAS_LOOKUP, 32'h0, 32'h5a5a_5a5a, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h0001_0000, 32'h0, 1, STAT_MISS, 4));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h0001_0000, 32'hffff_ffff, 1, STAT_MISS, 4));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h0, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'hffff_ffff, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h2100_0000, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h2100_0000, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_LOOKUP, 32'h2100_0000, 32'h0, 1, STAT_MISS, 0));
      directed_rows.push_back(mk_row(OP_INSERT, 32'h5555_aaaa, 32'haaaa_5555, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_ALIAS_LOOKUP, 32'h5555_aaaa, 32'h0, 0, STAT_OK, 0));
      directed_rows.push_back(mk_row(OP_DELETE, 32'h5555_aaaa, 32'h0, 0, STAT_OK, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].value,
                   directed_rows[r].typed, directed_rows[r].rsp);

      // mixed traffic, opened by a long receiver hold so the input backs up
      hold_req = 1'b1;
      random_items(250, 45, 25);

      // fill up to full, then overflow inserts and full-table misses
      guard = 0;
      while (occ_total < TABLE_SLOTS && guard < 700) begin
         random_items(1, 85, 8);
         guard++;
      end
      random_items(30, 50, 0);
      random_items(60, 45, 45);

      // sender goes idle and waits for the block to drain completely
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);

      hold_req = 1'b1;
      random_items(220, 10, 65);

      quiet = 1'b1;
      random_items(100, 40, 30);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 20) @(posedge clock);

      $display("tb: %0d requests sent, %0d responses checked, peak occupancy %0d of %0d",
               items_sent, rsp_checked, peak_occ, TABLE_SLOTS);
      $display("tb: %0d inserts into a full table, %0d key misses, %0d long response holds",
               full_seen, miss_seen, holds_done);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/htlp_pkg.sv
rtl/htlp_ram.sv
rtl/htlp_probe.sv
rtl/hash_table_linear_probe.sv
dv/tb.sv
